// ===== hdl/mqttpp_pkg.sv =====
package mqttpp_pkg;

  typedef enum logic [1:0] {
    KIND_TOPIC   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_PUB   = 3'd1,
    ST_TOPIC     = 3'd2,
    ST_MESSAGE   = 3'd3,
    ST_MALFORMED = 3'd4
  } status_e;

  // configuration register indexes
  localparam logic CFG_TOPIC_LIMIT   = 1'b0;
  localparam logic CFG_MESSAGE_LIMIT = 1'b1;

  localparam logic [15:0] TOPIC_LIMIT_RST   = 16'd64;
  localparam logic [28:0] MESSAGE_LIMIT_RST = 29'd1024;

  // upper nibble of a PUBLISH fixed header
  localparam logic [3:0] PUBLISH_TYPE = 4'h3;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    status_e     status;
    logic        last;
  } result_t;

  // up to two result words produced by one input byte, in order
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic result_t status_word(status_e code);
    result_t r;
    r.kind   = KIND_STATUS;
    r.data   = 8'd0;
    r.status = code;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic result_t data_word(kind_e kind, logic [7:0] data);
    result_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = ST_OK;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/mqttpp_parse.sv =====
module mqttpp_parse import mqttpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        packet_start_i,
  input  logic [15:0] topic_limit_i,
  input  logic [28:0] message_limit_i,
  output push_t       push_o
);

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_LEN_PUB,
    PH_LEN_OTHER,
    PH_TLEN_HI,
    PH_TLEN_LO,
    PH_TOPIC,
    PH_PID_HI,
    PH_PID_LO,
    PH_PAYLOAD,
    PH_SKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [27:0] rc_q, rc_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] topic_q, topic_d;
  logic [15:0] field_q, field_d;
  logic        pid_q, pid_d;
  status_e     skip_q, skip_d;

  logic [27:0] len_add;
  logic [27:0] rc_sum;
  logic [2:0]  idx_inc;
  logic [27:0] rc_dec;
  logic        body_end;
  logic [15:0] topic_full;
  logic [16:0] need;
  logic [28:0] diff;
  logic        topic_over;
  logic        too_short;
  logic        too_big;
  logic [15:0] field_dec;
  phase_e      after_topic;
  push_t       push;

  // 7-bit groups of the remaining length, least significant first
  always_comb begin
    case (idx_q[1:0])
      2'd0:    len_add = {21'd0, rx_byte_i[6:0]};
      2'd1:    len_add = {14'd0, rx_byte_i[6:0], 7'd0};
      2'd2:    len_add = {7'd0, rx_byte_i[6:0], 14'd0};
      default: len_add = {rx_byte_i[6:0], 21'd0};
    endcase
  end

  assign rc_sum     = rc_q + len_add;
  assign idx_inc    = idx_q + 3'd1;
  assign rc_dec     = rc_q - 28'd1;
  assign body_end   = (rc_dec == 28'd0);
  assign topic_full = {topic_q[15:8], rx_byte_i};
  assign need       = {1'b0, topic_full} + {15'd0, pid_q, 1'b0};
  assign diff       = {1'b0, rc_dec} - {12'd0, need};
  assign topic_over = (topic_full >= topic_limit_i);
  assign too_short  = diff[28];
  assign too_big    = ({1'b0, diff[27:0]} >= message_limit_i);
  assign field_dec  = field_q - 16'd1;
  assign after_topic = pid_q ? PH_PID_HI : PH_PAYLOAD;

  always_comb begin
    phase_d = phase_q;
    rc_d    = rc_q;
    idx_d   = idx_q;
    topic_d = topic_q;
    field_d = field_q;
    pid_d   = pid_q;
    skip_d  = skip_q;
    push    = '0;
    if (accept_i) begin
      // forced start cuts the running packet
      if (packet_start_i && phase_q != PH_HEADER) begin
        push.v0 = 1'b1;
        push.r0 = status_word(ST_MALFORMED);
      end
      if (packet_start_i || phase_q == PH_HEADER) begin
        rc_d    = '0;
        idx_d   = '0;
        topic_d = '0;
        field_d = '0;
        pid_d   = |rx_byte_i[2:1];
        phase_d = (rx_byte_i[7:4] == PUBLISH_TYPE) ? PH_LEN_PUB : PH_LEN_OTHER;
      end else begin
        unique case (phase_q)
          PH_LEN_PUB, PH_LEN_OTHER: begin
            rc_d  = rc_sum;
            idx_d = idx_inc;
            if (rx_byte_i[7]) begin
              if (idx_inc[2]) begin
                push.v0 = 1'b1;
                push.r0 = status_word(ST_MALFORMED);
                phase_d = PH_HEADER;
              end
            end else if (rc_sum == 28'd0) begin
              push.v0 = 1'b1;
              push.r0 = status_word((phase_q == PH_LEN_PUB) ? ST_MALFORMED : ST_NOT_PUB);
              phase_d = PH_HEADER;
            end else if (phase_q == PH_LEN_PUB) begin
              phase_d = PH_TLEN_HI;
            end else begin
              phase_d = PH_SKIP;
              skip_d  = ST_NOT_PUB;
            end
          end
          PH_TLEN_HI: begin
            rc_d    = rc_dec;
            topic_d = {rx_byte_i, 8'd0};
            if (body_end) begin
              push.v0 = 1'b1;
              push.r0 = status_word(ST_MALFORMED);
              phase_d = PH_HEADER;
            end else begin
              phase_d = PH_TLEN_LO;
            end
          end
          PH_TLEN_LO: begin
            rc_d    = rc_dec;
            topic_d = topic_full;
            if (topic_over || too_short || too_big) begin
              if (topic_over) begin
                skip_d = ST_TOPIC;
              end else if (too_short) begin
                skip_d = ST_MALFORMED;
              end else begin
                skip_d = ST_MESSAGE;
              end
              if (body_end) begin
                push.v0 = 1'b1;
                push.r0 = status_word(skip_d);
                phase_d = PH_HEADER;
              end else begin
                phase_d = PH_SKIP;
              end
            end else if (body_end) begin
              push.v0 = 1'b1;
              push.r0 = status_word(ST_OK);
              phase_d = PH_HEADER;
            end else begin
              field_d = topic_full;
              phase_d = (topic_full != 16'd0) ? PH_TOPIC : after_topic;
            end
          end
          PH_TOPIC: begin
            rc_d    = rc_dec;
            field_d = field_dec;
            push.v0 = 1'b1;
            push.r0 = data_word(KIND_TOPIC, rx_byte_i);
            if (body_end) begin
              push.v1 = 1'b1;
              push.r1 = status_word(ST_OK);
              phase_d = PH_HEADER;
            end else if (field_dec == 16'd0) begin
              phase_d = after_topic;
            end
          end
          PH_PID_HI, PH_PID_LO: begin
            rc_d = rc_dec;
            if (body_end) begin
              push.v0 = 1'b1;
              push.r0 = status_word(ST_OK);
              phase_d = PH_HEADER;
            end else begin
              phase_d = (phase_q == PH_PID_HI) ? PH_PID_LO : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            rc_d    = rc_dec;
            push.v0 = 1'b1;
            push.r0 = data_word(KIND_PAYLOAD, rx_byte_i);
            if (body_end) begin
              push.v1 = 1'b1;
              push.r1 = status_word(ST_OK);
              phase_d = PH_HEADER;
            end
          end
          PH_SKIP: begin
            rc_d = rc_dec;
            if (body_end) begin
              push.v0 = 1'b1;
              push.r0 = status_word(skip_q);
              phase_d = PH_HEADER;
            end
          end
          default: begin
            phase_d = PH_HEADER;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      rc_q    <= '0;
      idx_q   <= '0;
      topic_q <= '0;
      field_q <= '0;
      pid_q   <= 1'b0;
      skip_q  <= ST_OK;
    end else begin
      phase_q <= phase_d;
      rc_q    <= rc_d;
      idx_q   <= idx_d;
      topic_q <= topic_d;
      field_q <= field_d;
      pid_q   <= pid_d;
      skip_q  <= skip_d;
    end
  end

  assign push_o = push;

  // a second word is only ever the status that follows a data word
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.v1 |-> push.v0 && push.r0.kind != KIND_STATUS && push.r1.kind == KIND_STATUS)
    else $error("second result word out of order");

  // topic counter never idles at zero inside the topic
  a_topic_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TOPIC |-> field_q != 16'd0)
    else $error("topic counter empty in topic phase");

  // a skipped body always carries an error code
  a_skip_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> skip_q != ST_OK)
    else $error("skip phase without error code");

endmodule

// ===== hdl/mqttpp_outq.sv =====
module mqttpp_outq import mqttpp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_word_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t         mem_q [DEPTH];
  logic [IW-1:0]   wr_q, wr_d, wr_nxt;
  logic [IW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            pop;

  function automatic logic [IW-1:0] wrap_inc(logic [IW-1:0] p);
    return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
  endfunction

  assign pop    = out_valid_o && out_ready_i;
  assign wr_nxt = wrap_inc(wr_q);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push_i.v0) begin
      wr_d = push_i.v1 ? wrap_inc(wr_nxt) : wr_nxt;
    end
    if (pop) begin
      rd_d = wrap_inc(rd_q);
    end
    cnt_d = cnt_q + CW'(push_i.v0) + CW'(push_i.v1) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_nxt] <= push_i.r1;
    end
  end

  // room for the worst case of two words from one byte
  assign space_o     = (cnt_q <= CW'(DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = mem_q[rd_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> space_o)
    else $error("push into full result queue");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && cnt_q == CW'(1) && !push_i.v0 |=> !out_valid_o)
    else $error("result queue count lost track");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("result queue count above depth");

endmodule

// ===== hdl/mqtt_publish_parser_top.sv =====
// MQTT PUBLISH parser.
// Input channel: one packet byte per word (rx_byte_i) with packet_start_i to
// force a fixed header, valid/ready handshake on in_valid_i / in_ready_o.
// Output channel: tagged words (kind_o topic/payload/status, data_byte_o,
// status_o, last_o) on out_valid_o / out_ready_i. A status word with last_o
// set closes each packet; a topic or payload byte that completes a body yields
// its data word followed by the status word.
// Config: cfg_we_i writes cfg_data_i into topic limit (index 0) or message
// limit (index 1) on the same edge; change only while idle.
// Output: with an empty queue a result word shows on the output in the cycle
// after its byte is taken; words queued behind others wait their turn.
// Throughput: one byte per cycle while in_ready_o is high; the
// header/length/topic state update feeds an OUTQ_DEPTH-word result queue.
// Stall: the queue absorbs up to two words per byte; in_ready_o drops once
// fewer than two free entries remain and returns as the receiver drains.
// Reset: queue empty, parser waits for a header, limits return to 64 and 1024.
module mqtt_publish_parser_top import mqttpp_pkg::*; #(
  parameter int unsigned OUTQ_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [28:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        packet_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  logic [15:0] topic_limit_q;
  logic [28:0] message_limit_q;
  logic        accept;
  push_t       push;
  result_t     out_word;

  // limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topic_limit_q   <= TOPIC_LIMIT_RST;
      message_limit_q <= MESSAGE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOPIC_LIMIT:   topic_limit_q   <= cfg_data_i[15:0];
        CFG_MESSAGE_LIMIT: message_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  mqttpp_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .rx_byte_i       (rx_byte_i),
    .packet_start_i  (packet_start_i),
    .topic_limit_i   (topic_limit_q),
    .message_limit_i (message_limit_q),
    .push_o          (push)
  );

  mqttpp_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word)
  );

  assign kind_o      = out_word.kind;
  assign data_byte_o = out_word.data;
  assign status_o    = out_word.status;
  assign last_o      = out_word.last;

endmodule

// ===== tb/tb_mqtt_publish_parser_top.sv =====
`timescale 1ns / 1ps

module tb_mqtt_publish_parser_top import mqttpp_pkg::*;;

  // cycles without any handshake on either channel before the run is declared hung
  localparam int unsigned STALL_LIMIT  = 2000;
  // settle time after the last result: covers bytes that produce no word
  localparam int unsigned QUIET_CYCLES = 8;

  // parser phases as tracked by the prediction
  typedef enum logic [3:0] {
    PH_HDR,
    PH_LEN_PUB,
    PH_LEN_OTHER,
    PH_TLEN_HI,
    PH_TLEN_LO,
    PH_TOPIC,
    PH_PID_HI,
    PH_PID_LO,
    PH_PAYLOAD,
    PH_SKIP
  } parse_ph_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [28:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        packet_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  status_o;
  logic        last_o;

  // stimulus bytes not yet driven, and words the parser must still emit
  rx_word_t    rx_stream[$];
  result_t     parsed_words[$];
  int unsigned stream_bytes = 0;
  logic        force_start = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles = 0;
  int          err_cnt = 0;

  // shadow of the limit registers, reset values
  logic [15:0] lim_topic = TOPIC_LIMIT_RST;
  logic [28:0] lim_msg   = MESSAGE_LIMIT_RST;

  // predicted parser state
  parse_ph_e   ph = PH_HDR;
  status_e     skip_code = ST_OK;
  logic [27:0] rem_cnt = '0;
  logic [2:0]  len_idx = '0;
  logic [15:0] topic_sz = '0;
  logic [15:0] topic_left = '0;
  logic        pid_follows = 1'b0;

  // Opening bytes, {start, byte}:
  //  stray header while idle + zero length PUBLISH -> malformed
  //  QoS 1 PUBLISH, topic "ab", packet id, one payload byte -> ok
  //  QoS 3 header with four continued length bytes -> malformed at once
  //  maximum remaining length, topic length 65535 -> topic too long, skipped,
  //    then cut by a forced start -> malformed; new packet with empty topic -> ok
  //  non-PUBLISH type with a one byte body -> not publish
  logic [8:0] opening_seq[$] = '{
    9'h030, 9'h000,
    9'h13B, 9'h007, 9'h000, 9'h002, 9'h061, 9'h062, 9'h012, 9'h034, 9'h0FF,
    9'h136, 9'h080, 9'h0FF, 9'h0C1, 9'h080,
    9'h130, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h0FF, 9'h0FF,
    9'h131, 9'h002, 9'h000, 9'h000,
    9'h1F0, 9'h001, 9'h055
  };

  mqtt_publish_parser_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .packet_start_i (packet_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic emit(input kind_e kind, input logic [7:0] data, input status_e code,
                      input logic last);
    result_t w;
    w.kind   = kind;
    w.data   = data;
    w.status = code;
    w.last   = last;
    parsed_words.push_back(w);
  endtask

  // status word closes the packet, parser goes back to waiting for a header
  task automatic close_packet(input status_e code);
    emit(KIND_STATUS, 8'h00, code, 1'b1);
    ph = PH_HDR;
  endtask

  // error found in the topic length field: report now if the body is done,
  // otherwise swallow the rest and report at its end
  task automatic abort_body(input status_e code, input logic body_end);
    if (body_end) begin
      close_packet(code);
    end else begin
      ph        = PH_SKIP;
      skip_code = code;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic start);
    logic        body_end;
    logic [27:0] need;
    // forced start cuts an unfinished packet
    if (start && ph != PH_HDR) close_packet(ST_MALFORMED);
    if (ph == PH_HDR) begin
      rem_cnt     = '0;
      len_idx     = '0;
      topic_sz    = '0;
      topic_left  = '0;
      pid_follows = (b[2:1] != 2'b00);
      ph          = (b[7:4] == PUBLISH_TYPE) ? PH_LEN_PUB : PH_LEN_OTHER;
    end else if (ph == PH_LEN_PUB || ph == PH_LEN_OTHER) begin
      // 7-bit groups, least significant first
      rem_cnt = rem_cnt + (28'(b[6:0]) << (7 * len_idx[1:0]));
      len_idx = len_idx + 3'd1;
      if (b[7]) begin
        if (len_idx >= 3'd4) close_packet(ST_MALFORMED);
      end else if (rem_cnt == '0) begin
        close_packet((ph == PH_LEN_PUB) ? ST_MALFORMED : ST_NOT_PUB);
      end else if (ph == PH_LEN_PUB) begin
        ph = PH_TLEN_HI;
      end else begin
        ph        = PH_SKIP;
        skip_code = ST_NOT_PUB;
      end
    end else begin
      rem_cnt  = rem_cnt - 28'd1;
      body_end = (rem_cnt == '0);
      case (ph)
        PH_TLEN_HI: begin
          topic_sz = {b, 8'h00};
          if (body_end) close_packet(ST_MALFORMED);
          else ph = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          topic_sz[7:0] = b;
          need = 28'(topic_sz) + (pid_follows ? 28'd2 : 28'd0);
          // topic limit first, then body too short, then payload limit
          if (topic_sz >= lim_topic) begin
            abort_body(ST_TOPIC, body_end);
          end else if (rem_cnt < need) begin
            abort_body(ST_MALFORMED, body_end);
          end else if (29'(rem_cnt - need) >= lim_msg) begin
            abort_body(ST_MESSAGE, body_end);
          end else if (body_end) begin
            close_packet(ST_OK);
          end else begin
            topic_left = topic_sz;
            if (topic_sz != '0) ph = PH_TOPIC;
            else ph = pid_follows ? PH_PID_HI : PH_PAYLOAD;
          end
        end
        PH_TOPIC: begin
          emit(KIND_TOPIC, b, ST_OK, 1'b0);
          topic_left = topic_left - 16'd1;
          if (body_end) close_packet(ST_OK);
          else if (topic_left == '0) ph = pid_follows ? PH_PID_HI : PH_PAYLOAD;
        end
        PH_PID_HI: begin
          if (body_end) close_packet(ST_OK);
          else ph = PH_PID_LO;
        end
        PH_PID_LO: begin
          if (body_end) close_packet(ST_OK);
          else ph = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          emit(KIND_PAYLOAD, b, ST_OK, 1'b0);
          if (body_end) close_packet(ST_OK);
        end
        PH_SKIP: begin
          if (body_end) close_packet(skip_code);
        end
        default: begin
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] data, input logic start);
    rx_word_t w;
    w.data  = data;
    w.start = start;
    rx_stream.push_back(w);
    stream_bytes++;
  endtask

  // remaining length, now and then padded with redundant zero groups
  task automatic put_len(input int unsigned val);
    int unsigned n;
    n = 1;
    while (n < 4 && (val >> (7 * n)) != 0) n++;
    if ($urandom_range(0, 9) == 0) n = $urandom_range(4, n);
    for (int i = 0; i < n; i++) begin
      put_byte(8'((val >> (7 * i)) & 127) | ((i < n - 1) ? 8'h80 : 8'h00), 1'b0);
    end
  endtask

  // One packet, shape picked by pick:
  //   0..59 well formed, 60..67 body shorter than declared fields,
  //   68..73 other packet type, 74..79 cut by the next forced start,
  //   80..84 four continued length bytes, 85..89 zero remaining length,
  //   90..94 line noise, 95..96 oversized topic, 97..99 oversized payload if lim_msg <= 40
  task automatic add_packet(input int unsigned pick);
    int unsigned tlen, plen, tmax, pmax, nib, keep;
    logic [7:0]  hdr;
    logic        hdr_start;
    logic [7:0]  body[$];
    hdr_start   = force_start || ($urandom_range(0, 4) != 0);
    force_start = 1'b0;
    if (pick >= 90 && pick < 95) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom), 1'($urandom));
      force_start = 1'b1;
      return;
    end
    if (pick >= 68 && pick < 74) begin
      nib = $urandom_range(0, 14);
      if (nib >= 3) nib++;
      hdr = {nib[3:0], 4'($urandom)};
    end else begin
      hdr = {PUBLISH_TYPE, 4'($urandom)};
    end
    put_byte(hdr, hdr_start);
    if (pick >= 85 && pick < 90) begin
      put_len(0);
      return;
    end
    if (pick >= 80 && pick < 85) begin
      repeat (4) put_byte(8'h80 | 8'($urandom), 1'b0);
      return;
    end
    if (pick >= 68 && pick < 74) begin
      repeat ($urandom_range(1, 8)) body.push_back(8'($urandom));
    end else begin
      tmax = (lim_topic > 11) ? 10 : lim_topic - 1;
      pmax = (lim_msg > 13) ? 12 : lim_msg - 1;
      tlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : $urandom_range(0, tmax);
      plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, pmax);
      if (pick >= 95 && pick < 97) tlen = $urandom_range(65535, lim_topic);
      if (pick >= 97 && lim_msg <= 40) plen = lim_msg + $urandom_range(0, 3);
      body.push_back(8'(tlen >> 8));
      body.push_back(8'(tlen));
      // an oversized topic is skipped anyway, a few bytes are enough
      repeat ((tlen > 20) ? $urandom_range(0, 4) : tlen) body.push_back(8'($urandom));
      if (hdr[2:1] != 2'b00) repeat (2) body.push_back(8'($urandom));
      repeat (plen) body.push_back(8'($urandom));
    end
    keep = body.size();
    if (pick >= 60 && pick < 68 && keep > 1) begin
      keep = $urandom_range(1, keep - 1);
      put_len(keep);
    end else begin
      put_len(body.size());
      if (pick >= 74 && pick < 80) begin
        keep        = $urandom_range(0, keep - 1);
        force_start = 1'b1;
      end
    end
    for (int i = 0; i < keep; i++) put_byte(body[i], 1'b0);
  endtask

  // all bytes sent, all words back, then a few quiet cycles
  task automatic wait_drained();
    while (rx_stream.size() != 0 || in_valid_i || parsed_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic idx, input logic [28:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TOPIC_LIMIT) lim_topic = val[15:0];
    else lim_msg = val;
  endtask

  // One setting of limits and idling. A nonzero chunk makes the sender hold
  // off until everything queued so far has come back.
  task automatic run_stage(input int unsigned s_pct, input int unsigned r_pct,
                           input logic wr_cfg, input logic [15:0] tl,
                           input logic [28:0] ml, input int unsigned budget,
                           input int unsigned chunk);
    int unsigned base, mark;
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (wr_cfg) begin
      // upper bits of the topic limit write are don't-care
      write_limit(CFG_TOPIC_LIMIT, {13'($urandom), tl});
      write_limit(CFG_MESSAGE_LIMIT, ml);
    end
    base = stream_bytes;
    mark = stream_bytes;
    while (stream_bytes - base < budget) begin
      add_packet($urandom_range(0, 99));
      if (chunk != 0 && stream_bytes - mark >= chunk) begin
        wait_drained();
        mark = stream_bytes;
      end
    end
    // finish on a complete packet so the parser is idle before the next write
    force_start = 1'b1;
    add_packet(0);
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: valid held until taken, each taken byte runs the prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    logic     vld_n;
    rx_word_t w;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      rx_byte_i      <= '0;
      packet_start_i <= 1'b0;
    end else begin
      vld_n = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        parse_byte(rx_byte_i, packet_start_i);
        vld_n = 1'b0;
      end
      if (!vld_n && rx_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w              = rx_stream.pop_front();
        rx_byte_i      <= w.data;
        packet_start_i <= w.start;
        vld_n          = 1'b1;
      end
      in_valid_i <= vld_n;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every word taken is checked against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (parsed_words.size() == 0) begin
          $error("unexpected word: kind %0d data %0h status %0d last %0d",
                 kind_o, data_byte_o, status_o, last_o);
          err_cnt++;
        end else begin
          want = parsed_words.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            err_cnt++;
          end
          if (data_byte_o !== want.data) begin
            $error("data_byte: expected %0h, got %0h", want.data, data_byte_o);
            err_cnt++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_cnt++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_o);
            err_cnt++;
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: no word moved on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset limits (64 / 1024); slow receiver
    send_idle_pct = 16;
    recv_idle_pct = 88;
    foreach (opening_seq[i]) put_byte(opening_seq[i][7:0], opening_seq[i][8]);
    run_stage(16, 88, 1'b0, 16'd0, 29'd0, 70, 0);
    // lowest limits: only empty topics and empty payloads pass
    run_stage(16, 88, 1'b1, 16'd1, 29'd1, 45, 0);
    // highest limits, slow sender: payload limit can never trip
    run_stage(88, 16, 1'b1, 16'd65535, 29'h1000_0000, 75, 0);
    // tight limits; topic errors common
    run_stage(88, 16, 1'b1, 16'd12, 29'd48, 75, 0);
    // no idling; sender drains the parser every few packets
    run_stage(0, 0, 1'b1, 16'($urandom_range(1, 40)), 29'($urandom_range(1, 100)), 75, 25);
    wait_drained();

    if (err_cnt == 0 && parsed_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== mqtt_publish_parser_top.f =====
hdl/mqttpp_pkg.sv
hdl/mqttpp_parse.sv
hdl/mqttpp_outq.sv
hdl/mqtt_publish_parser_top.sv
tb/tb_mqtt_publish_parser_top.sv
